@@ sv/assert_macros.svh @@
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define P2C_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2c checker: same-cycle rule violated");

// Next-cycle implication, ignored while reset is asserted.
`define P2C_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2c checker: next-cycle rule violated");

// Next-cycle implication that also holds across reset.
`define P2C_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("p2c checker: reset rule violated");

`endif

@@ sv/p2c_pkg.sv @@
`default_nettype none
package p2c_pkg;

  localparam int unsigned NumPlanes = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH_BYTES = 2'd0;
  localparam logic [1:0] CFG_HEIGHT      = 2'd1;
  localparam logic [1:0] CFG_PLANE_SIZE  = 2'd2;
  localparam logic [1:0] CFG_MASKED      = 2'd3;

  // colour plane that triggers pixel output
  localparam logic [1:0] PLANE_LAST = 2'(NumPlanes - 1);

  // one store access, issued at the accepting edge
  typedef struct packed {
    logic        wr_mask;   // write mask byte
    logic        wr_plane;  // write one byte lane of the plane store
    logic        rd;        // read both stores, pixel group follows
    logic [1:0]  plane_sel; // colour plane of the byte
    logic [11:0] off;       // image offset
    logic [7:0]  data;      // stream byte
    logic [7:0]  row;
    logic [5:0]  col;
    logic        last;
    logic        masked;
  } p2c_cmd_t;

endpackage
`default_nettype wire

@@ sv/p2c_ctrl.sv @@
`default_nettype none
module p2c_ctrl #(
  parameter int unsigned MAX_PLANE_BYTES = 2048
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [11:0]    cfg_wdata,
  input  wire logic           in_fire,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_first,
  output logic                busy,
  output p2c_pkg::p2c_cmd_t   cmd
);
  import p2c_pkg::*;

  localparam logic [16:0] MaxBytes = 17'(MAX_PLANE_BYTES);
  // twelve offset bits, one quotient bit per cycle
  localparam logic [3:0]  DivLastStep = 4'd11;

  logic [6:0]  width_r;
  logic [7:0]  height_r;
  logic [11:0] psize_r;
  logic        masked_r;

  logic [2:0]  pidx_r, pidx_nxt;
  logic [11:0] off_r, off_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [5:0]  col_r, col_nxt;

  logic [2:0]  pidx_e;
  logic [11:0] off_e;
  logic [7:0]  row_e;
  logic [5:0]  col_e;
  logic [14:0] img_bytes;
  logic [2:0]  total;
  logic        cfg_ok, active, in_img, plane_end, is_mask, col_wrap;
  logic [1:0]  psel;

  logic        div_busy_r;
  logic [3:0]  div_cnt_r;
  logic [11:0] div_num_r;
  logic [6:0]  div_rem_r, div_rem_nxt;
  logic [11:0] div_quo_r, div_quo_nxt;
  logic [7:0]  div_trial, div_diff;
  logic        div_sub, div_done, width_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd2;
      height_r <= 8'd16;
      psize_r  <= 12'd32;
      masked_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WIDTH_BYTES: width_r  <= cfg_wdata[6:0];
        CFG_HEIGHT:      height_r <= cfg_wdata[7:0];
        CFG_PLANE_SIZE:  psize_r  <= cfg_wdata;
        CFG_MASKED:      masked_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    img_bytes = 15'(width_r) * 15'(height_r);
    cfg_ok = (width_r != 7'd0) && (width_r <= 7'd64) && (height_r != 8'd0) &&
             (psize_r != 12'd0) && ({5'd0, psize_r} <= MaxBytes) &&
             ({3'd0, psize_r} >= img_bytes);
    total  = 3'(NumPlanes) + {2'd0, masked_r};

    pidx_e = in_first ? 3'd0  : pidx_r;
    off_e  = in_first ? 12'd0 : off_r;
    row_e  = in_first ? 8'd0  : row_r;
    col_e  = in_first ? 6'd0  : col_r;

    active    = cfg_ok && (pidx_e < total);
    in_img    = {3'd0, off_e} < img_bytes;
    plane_end = ({1'b0, off_e} + 13'd1) >= {1'b0, psize_r};
    is_mask   = masked_r && (pidx_e == 3'd0);
    psel      = 2'(pidx_e - {2'd0, masked_r});
    col_wrap  = ({1'b0, col_e} + 7'd1) >= width_r;

    pidx_nxt = pidx_e;
    off_nxt  = off_e;
    row_nxt  = row_e;
    col_nxt  = col_e;
    if (cfg_ok && !active) begin
      pidx_nxt = total;
    end else if (active) begin
      if (plane_end) begin
        pidx_nxt = pidx_e + 3'd1;
        off_nxt  = 12'd0;
        row_nxt  = 8'd0;
        col_nxt  = 6'd0;
      end else begin
        off_nxt = off_e + 12'd1;
        if (col_wrap) begin
          col_nxt = 6'd0;
          row_nxt = row_e + 8'd1;
        end else begin
          col_nxt = col_e + 6'd1;
        end
      end
    end

    cmd.wr_mask   = in_fire && active && in_img && is_mask;
    cmd.wr_plane  = in_fire && active && in_img && !is_mask && (psel != PLANE_LAST);
    cmd.rd        = in_fire && active && in_img && !is_mask && (psel == PLANE_LAST);
    cmd.plane_sel = psel;
    cmd.off       = off_e;
    cmd.data      = in_byte;
    cmd.row       = row_e;
    cmd.col       = col_e;
    cmd.last      = ({3'd0, off_e} + 15'd1) == img_bytes;
    cmd.masked    = masked_r;
  end

  // restoring divide of the byte offset by width_bytes; a width write
  // rebuilds row and column from the offset, input waits meanwhile
  always_comb begin
    width_wr    = cfg_we && (cfg_addr == CFG_WIDTH_BYTES);
    div_trial   = {div_rem_r, div_num_r[11]};
    div_diff    = div_trial - {1'b0, width_r};
    div_sub     = div_trial >= {1'b0, width_r};
    div_rem_nxt = div_sub ? div_diff[6:0] : div_trial[6:0];
    div_quo_nxt = {div_quo_r[10:0], div_sub};
    div_done    = div_busy_r && (div_cnt_r == DivLastStep);
  end

  assign busy = div_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= 4'd0;
      div_num_r  <= 12'd0;
      div_rem_r  <= 7'd0;
      div_quo_r  <= 12'd0;
    end else if (width_wr) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 4'd0;
      div_num_r  <= off_r;
      div_rem_r  <= 7'd0;
      div_quo_r  <= 12'd0;
    end else if (div_busy_r) begin
      div_busy_r <= !div_done;
      div_cnt_r  <= div_cnt_r + 4'd1;
      div_num_r  <= {div_num_r[10:0], 1'b0};
      div_rem_r  <= div_rem_nxt;
      div_quo_r  <= div_quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r <= 3'd0;
      off_r  <= 12'd0;
      row_r  <= 8'd0;
      col_r  <= 6'd0;
    end else if (in_fire) begin
      pidx_r <= pidx_nxt;
      off_r  <= off_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end else if (div_done) begin
      row_r  <= div_quo_nxt[7:0];
      col_r  <= div_rem_nxt[5:0];
    end
  end

endmodule
`default_nettype wire

@@ sv/p2c_store.sv @@
`default_nettype none
module p2c_store #(
  parameter int unsigned MAX_PLANE_BYTES = 2048
) (
  input  wire logic              clk,
  input  p2c_pkg::p2c_cmd_t      cmd,
  output logic [7:0]             mask_q,
  output logic [23:0]            plane_q
);
  import p2c_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PLANE_BYTES);

  logic [7:0]  mask_mem  [MAX_PLANE_BYTES];
  logic [23:0] plane_mem [MAX_PLANE_BYTES];
  logic [16:0] off_ext;
  logic [AW-1:0] addr;

  assign off_ext = {5'd0, cmd.off};
  assign addr    = off_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_mask) mask_mem[addr] <= cmd.data;
    if (cmd.rd)      mask_q <= mask_mem[addr];
  end

  // byte-lane write, one lane per colour plane
  always_ff @(posedge clk) begin
    if (cmd.wr_plane) begin
      case (cmd.plane_sel)
        2'd0:    plane_mem[addr][7:0]   <= cmd.data;
        2'd1:    plane_mem[addr][15:8]  <= cmd.data;
        default: plane_mem[addr][23:16] <= cmd.data;
      endcase
    end
    if (cmd.rd) plane_q <= plane_mem[addr];
  end

endmodule
`default_nettype wire

@@ sv/p2c_out.sv @@
`default_nettype none
module p2c_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  p2c_pkg::p2c_cmd_t  cmd,
  input  wire logic [7:0]    mask_q,
  input  wire logic [23:0]   plane_q,
  output logic               in_ready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [55:0]        out_tdata,
  output logic               out_tlast
);
  import p2c_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_row_r;
  logic [5:0] s1_col_r;
  logic       s1_last_r, s1_masked_r;
  logic       s1_adv;

  logic [31:0] colors;
  logic [7:0]  opaque;
  logic [31:0] planes;

  logic [55:0] tdata_r;
  logic        tlast_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = cmd.rd ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // transpose: pixel i takes bit 7-i of each plane, MSB is leftmost
  always_comb begin
    planes = {s1_byte_r, plane_q};
    for (int i = 0; i < 8; i++) begin
      for (int q = 0; q < 4; q++) begin
        colors[4*i+q] = planes[8*q + 7 - i];
      end
      opaque[i] = !s1_masked_r || !mask_q[7-i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      s1_byte_r   <= cmd.data;
      s1_row_r    <= cmd.row;
      s1_col_r    <= cmd.col;
      s1_last_r   <= cmd.last;
      s1_masked_r <= cmd.masked;
    end
    if (s1_adv) begin
      tdata_r <= {2'b00, s1_col_r, s1_row_r, opaque, colors};
      tlast_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tlast  = tlast_r;

endmodule
`default_nettype wire

@@ sv/planar_to_chunky_masked_decoder.sv @@
`default_nettype none
// Planar-to-chunky decoder: accepts one stream byte per cycle (optional mask
// plane, then colour planes 0..3, each plane_size bytes with padding after
// width_bytes*height image bytes). Mask and planes 0-2 go into two on-chip
// memories (MAX_PLANE_BYTES deep, one access per item, registered read); each
// image byte of plane 3 reads both memories and, through the read stage
// and the output register, yields one item of eight 4-bit pixels with
// opaque flags, row, byte column and tlast on the final group. Sustained
// rate is one item per cycle; in_tready falls while a result sits in the
// read stage and the output register is held by out_tready low, and after
// each width_bytes write while row and column are rebuilt from the byte
// offset by a bit-per-cycle divide. The memories have no reset and no
// clearing pass: only entries written by the current image are used.
// Invalid register settings drop all bytes; in_tuser set restarts an image.
module planar_to_chunky_masked_decoder #(
  parameter int unsigned MAX_PLANE_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // [7:0] data_byte
  input  wire logic        in_tuser,  // [0] first
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata, // [31:0] pixel_colors, [39:32] opaque_bits,
                                      // [47:40] row, [53:48] byte_column, [55:54] 0
  output logic             out_tlast  // last
);
  import p2c_pkg::*;

  p2c_cmd_t    cmd;
  logic [7:0]  mask_q;
  logic [23:0] plane_q;
  logic        in_fire;
  logic        out_ready;
  logic        ctrl_busy;

  assign in_tready = out_ready && !ctrl_busy;
  assign in_fire   = in_tvalid && in_tready;

  // position counters and register file, issues one store access per item
  p2c_ctrl #(.MAX_PLANE_BYTES(MAX_PLANE_BYTES)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_fire, .in_byte(in_tdata), .in_first(in_tuser),
    .busy(ctrl_busy), .cmd
  );

  // mask and colour plane memories; a read of an entry always follows the
  // writes of that entry, so no forwarding is needed
  p2c_store #(.MAX_PLANE_BYTES(MAX_PLANE_BYTES)) u_store (
    .clk, .cmd, .mask_q, .plane_q
  );

  // read stage, pixel transpose and output register
  p2c_out u_out (
    .clk, .rst_n, .cmd, .mask_q, .plane_q,
    .in_ready(out_ready),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
`default_nettype wire

@@ sv/p2c_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module p2c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_addr,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast
);
  import p2c_pkg::*;

  // held result keeps valid and payload
  `P2C_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `P2C_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  // a width write holds off input while row and column are rebuilt
  `P2C_ASSERT_NXT(a_resync_stall, cfg_we && (cfg_addr == CFG_WIDTH_BYTES), !in_tready)
  // pad bits of the result stay zero
  `P2C_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[55:54] == 2'b00)
  // no result right after reset
  `P2C_ASSERT_RST(a_reset_idle, !rst_n, !out_tvalid)
endmodule

bind planar_to_chunky_masked_decoder p2c_checker u_p2c_checker (.*);
`default_nettype wire
